// File: hdl/sslm_pkg.sv
`default_nettype none
package sslm_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int PIXEL_BITS = 8;
	localparam int ROW_BITS   = 12;
	localparam int COL_BITS   = 10;
	localparam int WID_BITS   = 11;
	localparam int CFG_BITS   = 12;
	localparam int TRIPLE_BITS = 3 * PIXEL_BITS;
	localparam int LINE_BITS   = 2 * TRIPLE_BITS;

	localparam logic [WID_BITS-1:0] WIDTH_MIN   = WID_BITS'(3);
	localparam logic [WID_BITS-1:0] WIDTH_MAX   = WID_BITS'(MAX_WIDTH);
	localparam logic [WID_BITS-1:0] WIDTH_RST   = WID_BITS'(640);
	localparam logic [ROW_BITS-1:0] HEIGHT_MIN  = ROW_BITS'(3);
	localparam logic [ROW_BITS-1:0] HEIGHT_RST  = ROW_BITS'(480);

	localparam logic [PIXEL_BITS-1:0] MARK_MAX  = PIXEL_BITS'(255);
	localparam logic [PIXEL_BITS-1:0] MARK_NONE = PIXEL_BITS'(0);

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [PIXEL_BITS-1:0]  pixel_t;
	typedef logic [TRIPLE_BITS-1:0] triple_t;
	typedef logic [LINE_BITS-1:0]   line_word_t;

endpackage
`default_nettype wire

// File: hdl/sslm_if.sv
`default_nettype none
interface sslm_pixel_if;
	logic                  valid;
	logic                  ready;
	sslm_pkg::pixel_t      below_pixel;
	sslm_pkg::pixel_t      target_pixel;
	sslm_pkg::pixel_t      above_pixel;
	logic                  frame_start;

	modport source (output valid, below_pixel, target_pixel, above_pixel, frame_start,
		input ready);
	modport sink (input valid, below_pixel, target_pixel, above_pixel, frame_start,
		output ready);
endinterface

interface sslm_result_if;
	logic                              valid;
	logic                              ready;
	logic [sslm_pkg::ROW_BITS-1:0]     center_row;
	logic [sslm_pkg::COL_BITS-1:0]     center_col;
	sslm_pkg::pixel_t                  marker;

	modport source (output valid, center_row, center_col, marker, input ready);
	modport sink (input valid, center_row, center_col, marker, output ready);
endinterface

interface sslm_cfg_if;
	logic                              valid;
	logic                              ready;
	sslm_pkg::reg_idx_t                index;
	logic [sslm_pkg::CFG_BITS-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/scale_space_local_max_3x3x3.sv
`default_nettype none
// 3x3x3 scale-space maximum detector. Takes one (below, target, above) pixel triple per clock
// in raster order and, for every interior target pixel, returns its row, column and a marker
// of 255 when it is strictly greater than all 26 neighbours, else 0; border pixels give no
// result. Throughput is one pixel per cycle unless result.ready stalls. The two previous
// lines of all three images sit in one 1024 x 48 single-port-read RAM; each entry is read
// when its pixel arrives and rewritten by the line stage, with a bypass for a read that
// meets the write of the same column. Width and height are set through the cfg channel
// (index 0: width, clamped to 3..1024; index 1: height, at least 3) and take effect at once;
// write them only while no pixel is in flight. frame_start resets the position to (0,0).
module scale_space_local_max_3x3x3 (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sslm_cfg_if.sink      cfg,
	sslm_pixel_if.sink    pixel,
	sslm_result_if.source result
);

	// configuration
	logic [sslm_pkg::WID_BITS-1:0] width_q;
	logic [sslm_pkg::ROW_BITS-1:0] height_q;
	logic [sslm_pkg::WID_BITS-1:0] w_eff;
	logic [sslm_pkg::ROW_BITS-1:0] h_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sslm_pkg::WIDTH_RST;
			height_q <= sslm_pkg::HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				sslm_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg.data[sslm_pkg::WID_BITS-1:0];
				sslm_pkg::REG_IMAGE_HEIGHT: height_q <= cfg.data[sslm_pkg::ROW_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < sslm_pkg::WIDTH_MIN) begin
			w_eff = sslm_pkg::WIDTH_MIN;
		end else if (width_q > sslm_pkg::WIDTH_MAX) begin
			w_eff = sslm_pkg::WIDTH_MAX;
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q < sslm_pkg::HEIGHT_MIN) ? sslm_pkg::HEIGHT_MIN : height_q;
	end

	// position counters
	logic                          accept;
	logic                          en;
	logic [sslm_pkg::ROW_BITS-1:0] row_q;
	logic [sslm_pkg::COL_BITS-1:0] col_q;
	logic [sslm_pkg::ROW_BITS-1:0] r0;
	logic [sslm_pkg::COL_BITS-1:0] c0;
	logic [sslm_pkg::WID_BITS-1:0] c0_inc;
	logic [sslm_pkg::ROW_BITS:0]   r0_inc;
	logic                          emit0;
	sslm_pkg::triple_t             cur0;

	logic                          valid_s1;
	logic                          emit_s1;
	logic [sslm_pkg::ROW_BITS-1:0] row_s1;
	logic [sslm_pkg::COL_BITS-1:0] col_s1;
	sslm_pkg::triple_t             cur_s1;
	logic                          byp_s1;
	sslm_pkg::line_word_t          byp_data_s1;

	logic                          valid_s2;
	logic [sslm_pkg::ROW_BITS-1:0] row_s2;
	logic [sslm_pkg::COL_BITS-1:0] col_s2;
	sslm_pkg::pixel_t              marker_s2;

	assign en           = !valid_s2 || result.ready;
	assign pixel.ready  = !valid_s1 || en;
	assign accept       = pixel.valid && pixel.ready;

	always_comb begin
		r0     = pixel.frame_start ? '0 : row_q;
		c0     = pixel.frame_start ? '0 : col_q;
		c0_inc = {1'b0, c0} + sslm_pkg::WID_BITS'(1);
		r0_inc = {1'b0, r0} + (sslm_pkg::ROW_BITS + 1)'(1);
		emit0  = (r0 >= sslm_pkg::ROW_BITS'(2)) && (c0 >= sslm_pkg::COL_BITS'(2))
			&& (r0 < h_eff) && ({1'b0, c0} < w_eff);
		cur0   = {pixel.above_pixel, pixel.target_pixel, pixel.below_pixel};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (c0_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (r0_inc >= {1'b0, h_eff}) ? '0 : r0_inc[sslm_pkg::ROW_BITS-1:0];
			end else begin
				col_q <= c0_inc[sslm_pkg::COL_BITS-1:0];
				row_q <= r0;
			end
		end
	end

	// line store
	logic                 wr_en;
	sslm_pkg::line_word_t rd_data;
	sslm_pkg::line_word_t line_word;
	sslm_pkg::line_word_t wr_data;
	sslm_pkg::triple_t    top_s1;
	sslm_pkg::triple_t    mid_s1;

	assign wr_en     = valid_s1 && en;
	assign line_word = byp_s1 ? byp_data_s1 : rd_data;
	assign top_s1    = line_word[sslm_pkg::LINE_BITS-1:sslm_pkg::TRIPLE_BITS];
	assign mid_s1    = line_word[sslm_pkg::TRIPLE_BITS-1:0];
	assign wr_data   = {mid_s1, cur_s1};

	sslm_ram #(
		.WIDTH (sslm_pkg::LINE_BITS),
		.DEPTH (sslm_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (c0),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1     <= emit0;
			row_s1      <= r0;
			col_s1      <= c0;
			cur_s1      <= cur0;
			byp_s1      <= wr_en && (col_s1 == c0);
			byp_data_s1 <= wr_data;
		end
	end

	// 3x3 window and compare
	sslm_pkg::triple_t win_q [3][3];
	sslm_pkg::triple_t nwin  [3][3];
	sslm_pkg::pixel_t  centre;
	logic              is_max;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nwin[i][0] = win_q[i][1];
			nwin[i][1] = win_q[i][2];
		end
		nwin[0][2] = top_s1;
		nwin[1][2] = mid_s1;
		nwin[2][2] = cur_s1;
		centre = nwin[1][1][2*sslm_pkg::PIXEL_BITS-1:sslm_pkg::PIXEL_BITS];
		is_max = 1'b1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					if (!(i == 1 && j == 1 && k == 1)) begin
						if (nwin[i][j][k*sslm_pkg::PIXEL_BITS +: sslm_pkg::PIXEL_BITS] >= centre) begin
							is_max = 1'b0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (wr_en) begin
			win_q <= nwin;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			row_s2    <= row_s1 - sslm_pkg::ROW_BITS'(1);
			col_s2    <= col_s1 - sslm_pkg::COL_BITS'(1);
			marker_s2 <= is_max ? sslm_pkg::MARK_MAX : sslm_pkg::MARK_NONE;
		end
	end

	assign result.valid      = valid_s2;
	assign result.center_row = row_s2;
	assign result.center_col = col_s2;
	assign result.marker     = marker_s2;

	// checks
	a_frame_start_origin: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pixel.frame_start |=> row_s1 == '0 && col_s1 == '0)
		else $error("frame start did not restart the position");

	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> row_s2 != '0 && col_s2 != '0)
		else $error("result for a border pixel");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en |=> valid_s1 && $stable(col_s1) && $stable(cur_s1))
		else $error("stalled pixel lost in line stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted pixel missing from line stage");

endmodule
`default_nettype wire

// File: hdl/sslm_ram.sv
`default_nettype none
module sslm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire
